[design/dnsa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dnsa_pkg
// Shared types and constants of the diffusion noise schedule block.
// ----------------------------------------------------------------------------
package dnsa_pkg;

    localparam int DEF_MAX_STEPS      = 1024;
    localparam int DEF_SAMPLE_BITS    = 16;
    localparam int DEF_COEF_FRAC_BITS = 24;

    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int STEP_W     = 10;
    localparam int BETA_W     = 24;
    localparam int NSTEPS_W   = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int PROD_W     = 33;

    localparam logic [CMD_W-1:0] CMD_BUILD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PRED  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_STEP      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_BUILT = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BETA      = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_BETA_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BETA_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_STEPS  = 2'd2;

    localparam logic [BETA_W-1:0]   RST_BETA_START = 24'd1678;
    localparam logic [BETA_W-1:0]   RST_BETA_END   = 24'd335544;
    localparam logic [NSTEPS_W-1:0] RST_NUM_STEPS  = 11'd1000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BDIV,
        ST_BMUL,
        ST_BPROD,
        ST_BSQRT,
        ST_EMUL,
        ST_ESUM,
        ST_EDIV,
        ST_DONE
    } dnsa_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } dnsa_unit_stat_t;

endpackage
`default_nettype wire

[design/dnsa_divu.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dnsa_divu
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dnsa_divu #(
    parameter int NUM_W = 42,
    parameter int DEN_W = 24
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic [NUM_W-1:0]         num,
    input  wire logic [DEN_W-1:0]         den,
    output dnsa_pkg::dnsa_unit_stat_t     stat,
    output logic      [NUM_W-1:0]         quot,
    output logic      [DEN_W-1:0]         rem
);
    import dnsa_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] r_reg;
    logic [DEN_W-1:0] d_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W-1:0] r_next;

    always_comb begin
        shifted = {r_reg, q_reg[NUM_W-1]};
        trial   = shifted - {1'b0, d_reg};
        ge      = shifted >= {1'b0, d_reg};
        r_next  = ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end else if (busy_reg) begin
            q_reg <= {q_reg[NUM_W-2:0], ge};
            r_reg <= r_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = q_reg;
    assign rem       = r_reg;

endmodule
`default_nettype wire

[design/dnsa_isqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dnsa_isqrt
// Integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module dnsa_isqrt #(
    parameter int ROOT_W = 24
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic [2*ROOT_W-1:0]     val,
    output dnsa_pkg::dnsa_unit_stat_t    stat,
    output logic      [ROOT_W-1:0]       root
);
    import dnsa_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [2*ROOT_W-1:0] v_reg;
    logic [ROOT_W-1:0]   q_reg;
    logic [ROOT_W:0]     r_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [ROOT_W+2:0]   r_sh;
    logic [ROOT_W+2:0]   trial;
    logic [ROOT_W+2:0]   r_sub;
    logic                ge;

    always_comb begin
        r_sh  = {r_reg, v_reg[2*ROOT_W-1 -: 2]};
        trial = {1'b0, q_reg, 2'b01};
        ge    = r_sh >= trial;
        r_sub = ge ? (r_sh - trial) : r_sh;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg <= val;
            q_reg <= '0;
            r_reg <= '0;
        end else if (busy_reg) begin
            v_reg <= v_reg << 2;
            q_reg <= {q_reg[ROOT_W-2:0], ge};
            r_reg <= r_sub[ROOT_W:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = q_reg;

endmodule
`default_nettype wire

[design/diffusion_noise_schedule_apply.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// diffusion_noise_schedule_apply
// Linear beta noise schedule: table build, forward noising, clean prediction.
// ----------------------------------------------------------------------------
// One item at a time. An add-noise item passes through coefficient memory read,
// multiply, sum and round, and result before the next item is accepted.
// A predict item adds the bit-serial divider when its keep coefficient is not
// zero. A build item runs one divider pass for the beta increment, unless the
// schedule has a single step, then per schedule step a multiply, a product
// update and the two bit-serial square roots.
// Both coefficients of a step sit in one entry of a single memory.
module diffusion_noise_schedule_apply #(
    parameter int MAX_STEPS      = dnsa_pkg::DEF_MAX_STEPS,
    parameter int SAMPLE_BITS    = dnsa_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = dnsa_pkg::DEF_COEF_FRAC_BITS,
    localparam int S_DATA_W = ((dnsa_pkg::STEP_W + 2 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int M_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [S_DATA_W-1:0]               s_tdata,  // step, sample, noise
    input  wire logic [dnsa_pkg::CMD_W-1:0]        s_tuser,  // command
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [M_DATA_W-1:0]               m_tdata,  // value
    output logic      [dnsa_pkg::STATUS_W-1:0]     m_tuser,  // status
    input  wire logic                              cfg_we,
    input  wire logic [dnsa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dnsa_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import dnsa_pkg::*;

    localparam int S      = SAMPLE_BITS;
    localparam int F      = COEF_FRAC_BITS;
    localparam int AW     = $clog2(MAX_STEPS);
    localparam int CNT_W  = $clog2(MAX_STEPS + 1);
    localparam int FAC_W  = BETA_W + 1;
    localparam int MUL_W  = PROD_W + FAC_W;
    localparam int PRD_W  = F + S;
    localparam int SUM_W  = S + F + 1;
    localparam int NW     = S + F + 2;
    localparam int DW     = F;
    localparam logic [NW-1:0]    NEG_MAG  = NW'(1) << (S - 1);
    localparam logic [NW-1:0]    POS_MAX  = NEG_MAG - NW'(1);
    localparam logic [NW-1:0]    HALF_LSB = NW'(1) << (F - 1);
    localparam logic [F-1:0]     COEF_MAX = '1;
    localparam logic [PROD_W-1:0] ONE_Q32 = PROD_W'(1) << 32;

    // configuration
    logic [BETA_W-1:0]   beta_start_reg;
    logic [BETA_W-1:0]   beta_end_reg;
    logic [NSTEPS_W-1:0] nsteps_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beta_start_reg <= RST_BETA_START;
            beta_end_reg   <= RST_BETA_END;
            nsteps_reg     <= RST_NUM_STEPS;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_BETA_START: beta_start_reg <= cfg_data[BETA_W-1:0];
                REG_BETA_END:   beta_end_reg   <= cfg_data[BETA_W-1:0];
                REG_NUM_STEPS:  nsteps_reg     <= cfg_data[NSTEPS_W-1:0];
                default: ;
            endcase
        end
    end

    // input unpacking
    logic [STEP_W-1:0] in_step;
    logic [S-1:0]      in_sample;
    logic [S-1:0]      in_noise;
    logic              accept;

    assign in_step   = s_tdata[STEP_W-1:0];
    assign in_sample = s_tdata[STEP_W +: S];
    assign in_noise  = s_tdata[STEP_W+S +: S];
    assign accept    = s_tvalid && s_tready;

    // registers
    dnsa_state_t          state_reg, state_next;
    logic                 built_reg, built_next;
    logic [CNT_W-1:0]     built_steps_reg, built_steps_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic                 m_valid_reg, m_valid_next;
    logic [CNT_W-1:0]     t_reg, t_next;
    logic [BETA_W-1:0]    q_acc_reg, q_acc_next;
    logic [CNT_W-1:0]     r_acc_reg, r_acc_next;
    logic [BETA_W-1:0]    qc_reg, qc_next;
    logic [CNT_W-1:0]     rc_reg, rc_next;
    logic [MUL_W-1:0]     mul_reg, mul_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [S-1:0]         sample_reg, sample_next;
    logic [S-1:0]         noise_reg, noise_next;
    logic [F-1:0]         a_reg, a_next;
    logic [PRD_W-1:0]     pa_reg, pa_next;
    logic [PRD_W-1:0]     pb_reg, pb_next;
    logic                 neg_reg, neg_next;
    logic [S-1:0]         res_val_reg, res_val_next;
    logic [STATUS_W-1:0]  res_stat_reg, res_stat_next;
    logic [S-1:0]         m_val_reg, m_val_next;
    logic [STATUS_W-1:0]  m_stat_reg, m_stat_next;

    // coefficient memory, keep coefficient in the upper half
    logic [2*F-1:0] coef_mem [MAX_STEPS];
    logic [2*F-1:0] rd_reg;
    logic           coef_we;
    logic [2*F-1:0] coef_wdata;
    logic [F-1:0]   rd_a;
    logic [F-1:0]   rd_b;

    always_ff @(posedge aclk) begin
        if (coef_we) begin
            coef_mem[t_reg[AW-1:0]] <= coef_wdata;
        end
        rd_reg <= coef_mem[AW'(in_step)];
    end

    assign rd_a = rd_reg[2*F-1:F];
    assign rd_b = rd_reg[F-1:0];

    // shared arithmetic units
    dnsa_unit_stat_t div_stat, keep_stat, noise_stat;
    logic            div_start;
    logic [NW-1:0]   div_num;
    logic [DW-1:0]   div_den;
    logic [NW-1:0]   div_quot;
    logic [DW-1:0]   div_rem;
    logic            sq_start;
    logic [2*F-1:0]  keep_val;
    logic [2*F-1:0]  noise_val;
    logic [F-1:0]    keep_root;
    logic [F-1:0]    noise_root;

    dnsa_divu #(.NUM_W(NW), .DEN_W(DW)) u_divu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .stat    (div_stat),
        .quot    (div_quot),
        .rem     (div_rem)
    );

    dnsa_isqrt #(.ROOT_W(F)) u_sqrt_keep (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .val     (keep_val),
        .stat    (keep_stat),
        .root    (keep_root)
    );

    dnsa_isqrt #(.ROOT_W(F)) u_sqrt_noise (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .val     (noise_val),
        .stat    (noise_stat),
        .root    (noise_root)
    );

    // schedule arithmetic
    logic                beta_bad;
    logic                steps_bad;
    logic [CNT_W-1:0]    steps_cnt;
    logic [CNT_W-1:0]    d_cnt;
    logic [BETA_W-1:0]   diff;
    logic [BETA_W-1:0]   beta;
    logic [FAC_W-1:0]    fac;
    logic [MUL_W-1:0]    mul_rnd;
    logic [PROD_W-1:0]   prod_calc;
    logic [PROD_W-1:0]   rest_calc;
    logic [CNT_W:0]      r_sum;
    logic                r_wrap;
    logic                last_step;
    logic                step_bad;

    always_comb begin
        beta_bad  = (beta_start_reg == '0) || (beta_start_reg > beta_end_reg);
        steps_bad = (nsteps_reg == '0) || (32'(nsteps_reg) > 32'(MAX_STEPS));
        steps_cnt = CNT_W'(nsteps_reg);
        d_cnt     = steps_cnt - CNT_W'(1);
        diff      = beta_end_reg - beta_start_reg;
        beta      = beta_start_reg + q_acc_reg;
        fac       = (FAC_W'(1) << BETA_W) - FAC_W'(beta);
        mul_rnd   = mul_reg + (MUL_W'(1) << (BETA_W - 1));
        prod_calc = mul_rnd[BETA_W +: PROD_W];
        rest_calc = ONE_Q32 - prod_calc;
        keep_val  = (2*F)'(prod_calc[31:0]) << (2 * F - 32);
        noise_val = (2*F)'(rest_calc[31:0]) << (2 * F - 32);
        r_sum     = {1'b0, r_acc_reg} + {1'b0, rc_reg};
        r_wrap    = r_sum >= {1'b0, d_cnt};
        last_step = t_reg == d_cnt;
        step_bad  = 32'(in_step) >= 32'(built_steps_reg);
    end

    // element arithmetic
    logic             nx, nn;
    logic [S-1:0]     mx, mn;
    logic [SUM_W-1:0] t1, t2, sum;
    logic             n1, n2, sum_neg;
    logic [NW-1:0]    esum_mag;
    logic [NW-1:0]    esum_num;
    logic [NW-1:0]    sat_mag;
    logic             sat_neg;
    logic [NW-1:0]    sat_clip;
    logic [S-1:0]     sat_val;

    always_comb begin
        nx = sample_reg[S-1];
        nn = noise_reg[S-1];
        mx = nx ? (~sample_reg + S'(1)) : sample_reg;
        mn = nn ? (~noise_reg + S'(1)) : noise_reg;
        t1 = (cmd_reg == CMD_ADD) ? SUM_W'(pa_reg) : (SUM_W'(mx) << F);
        n1 = nx;
        t2 = SUM_W'(pb_reg);
        n2 = (cmd_reg == CMD_ADD) ? nn : !nn;
        if (n1 == n2) begin
            sum     = t1 + t2;
            sum_neg = n1;
        end else if (t1 >= t2) begin
            sum     = t1 - t2;
            sum_neg = n1;
        end else begin
            sum     = t2 - t1;
            sum_neg = n2;
        end
        if (cmd_reg == CMD_ADD) begin
            esum_mag = (NW'(sum) + HALF_LSB) >> F;
        end else begin
            esum_mag = (sum != '0) ? NEG_MAG : '0;
        end
        esum_num = NW'(sum) + NW'(a_reg >> 1);

        sat_mag = (state_reg == ST_EDIV) ? div_quot : esum_mag;
        sat_neg = (state_reg == ST_EDIV) ? neg_reg : sum_neg;
        if (sat_neg) begin
            sat_clip = (sat_mag > NEG_MAG) ? NEG_MAG : sat_mag;
            sat_val  = S'(~sat_clip + NW'(1));
        end else begin
            sat_clip = (sat_mag > POS_MAX) ? POS_MAX : sat_mag;
            sat_val  = S'(sat_clip);
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_tuser)
                        CMD_BUILD: begin
                            if (beta_bad || steps_bad) begin
                                state_next = ST_DONE;
                            end else if (steps_cnt == CNT_W'(1)) begin
                                state_next = ST_BMUL;
                            end else begin
                                state_next = ST_BDIV;
                            end
                        end
                        CMD_ADD, CMD_PRED: begin
                            if (!built_reg || step_bad) begin
                                state_next = ST_DONE;
                            end else begin
                                state_next = ST_EMUL;
                            end
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_BDIV:  if (div_stat.done) state_next = ST_BMUL;
            ST_BMUL:  state_next = ST_BPROD;
            ST_BPROD: state_next = ST_BSQRT;
            ST_BSQRT: begin
                if (keep_stat.done) begin
                    state_next = last_step ? ST_DONE : ST_BMUL;
                end
            end
            ST_EMUL:  state_next = ST_ESUM;
            ST_ESUM: begin
                if (cmd_reg == CMD_PRED && a_reg != '0) begin
                    state_next = ST_EDIV;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_EDIV:  if (div_stat.done) state_next = ST_DONE;
            ST_DONE:  if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        built_next       = built_reg;
        built_steps_next = built_steps_reg;
        prod_next        = prod_reg;
        t_next           = t_reg;
        q_acc_next       = q_acc_reg;
        r_acc_next       = r_acc_reg;
        qc_next          = qc_reg;
        rc_next          = rc_reg;
        mul_next         = mul_reg;
        cmd_next         = cmd_reg;
        sample_next      = sample_reg;
        noise_next       = noise_reg;
        a_next           = a_reg;
        pa_next          = pa_reg;
        pb_next          = pb_reg;
        neg_next         = neg_reg;
        res_val_next     = res_val_reg;
        res_stat_next    = res_stat_reg;
        m_val_next       = m_val_reg;
        m_stat_next      = m_stat_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        s_tready         = state_reg == ST_IDLE;
        div_start        = 1'b0;
        div_num          = esum_num;
        div_den          = a_reg;
        sq_start         = 1'b0;
        coef_we          = 1'b0;
        coef_wdata       = {keep_root, (prod_reg == '0) ? COEF_MAX : noise_root};

        case (state_reg)
            ST_IDLE: begin
                div_num = NW'(diff);
                div_den = DW'(d_cnt);
                if (accept) begin
                    cmd_next      = s_tuser;
                    sample_next   = in_sample;
                    noise_next    = in_noise;
                    res_val_next  = '0;
                    res_stat_next = STAT_OK;
                    case (s_tuser)
                        CMD_BUILD: begin
                            if (beta_bad) begin
                                res_stat_next = STAT_BETA;
                                built_next    = 1'b0;
                            end else if (steps_bad) begin
                                res_stat_next = STAT_STEP;
                                built_next    = 1'b0;
                            end else begin
                                built_next = 1'b0;
                                prod_next  = ONE_Q32;
                                t_next     = '0;
                                q_acc_next = '0;
                                r_acc_next = d_cnt >> 1;
                                qc_next    = '0;
                                rc_next    = '0;
                                div_start  = steps_cnt != CNT_W'(1);
                            end
                        end
                        CMD_ADD, CMD_PRED: begin
                            if (!built_reg) begin
                                res_stat_next = STAT_NOT_BUILT;
                            end else if (step_bad) begin
                                res_stat_next = STAT_STEP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_BDIV: begin
                if (div_stat.done) begin
                    qc_next = BETA_W'(div_quot);
                    rc_next = CNT_W'(div_rem);
                end
            end
            ST_BMUL: begin
                mul_next = MUL_W'(prod_reg) * MUL_W'(fac);
            end
            ST_BPROD: begin
                prod_next = prod_calc;
                sq_start  = 1'b1;
            end
            ST_BSQRT: begin
                if (keep_stat.done) begin
                    coef_we    = 1'b1;
                    r_acc_next = r_wrap ? CNT_W'(r_sum - {1'b0, d_cnt}) : CNT_W'(r_sum);
                    q_acc_next = q_acc_reg + qc_reg + BETA_W'(r_wrap);
                    t_next     = t_reg + CNT_W'(1);
                    if (last_step) begin
                        built_next       = 1'b1;
                        built_steps_next = steps_cnt;
                    end
                end
            end
            ST_EMUL: begin
                a_next  = rd_a;
                pa_next = PRD_W'(rd_a) * PRD_W'(mx);
                pb_next = PRD_W'(rd_b) * PRD_W'(mn);
            end
            ST_ESUM: begin
                neg_next = sum_neg;
                if (cmd_reg == CMD_PRED && a_reg != '0) begin
                    div_start = 1'b1;
                end else begin
                    res_val_next = sat_val;
                end
            end
            ST_EDIV: begin
                if (div_stat.done) begin
                    res_val_next = sat_val;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_val_next   = res_val_reg;
                    m_stat_next  = res_stat_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            built_reg       <= 1'b0;
            built_steps_reg <= '0;
            prod_reg        <= ONE_Q32;
            m_valid_reg     <= 1'b0;
            t_reg           <= '0;
        end else begin
            state_reg       <= state_next;
            built_reg       <= built_next;
            built_steps_reg <= built_steps_next;
            prod_reg        <= prod_next;
            m_valid_reg     <= m_valid_next;
            t_reg           <= t_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_acc_reg    <= q_acc_next;
        r_acc_reg    <= r_acc_next;
        qc_reg       <= qc_next;
        rc_reg       <= rc_next;
        mul_reg      <= mul_next;
        cmd_reg      <= cmd_next;
        sample_reg   <= sample_next;
        noise_reg    <= noise_next;
        a_reg        <= a_next;
        pa_reg       <= pa_next;
        pb_reg       <= pb_next;
        neg_reg      <= neg_next;
        res_val_reg  <= res_val_next;
        res_stat_reg <= res_stat_next;
        m_val_reg    <= m_val_next;
        m_stat_reg   <= m_stat_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'(m_val_reg);
    assign m_tuser  = m_stat_reg;

`ifndef SYNTHESIS
    a_sqrt_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        keep_stat.done |-> noise_stat.done)
        else $error("square root units out of step");

    a_div_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> $past(div_stat.busy))
        else $error("divider finished without running");

    a_mem_write_in_build: assert property (@(posedge aclk) disable iff (!aresetn)
        coef_we |-> (state_reg == ST_BSQRT) && !built_reg)
        else $error("coefficient write outside a build");

    a_product_below_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) && built_reg |-> !prod_reg[32])
        else $error("running product not below one after build");
`endif

endmodule
`default_nettype wire

[sim/tb_diffusion_noise_schedule_apply.sv]
// ----------------------------------------------------------------------------
// tb_diffusion_noise_schedule_apply
// Self-checking bench for the diffusion noise schedule block. A local model of
// the coefficient tables predicts value and status of every item; results are
// compared in order. Covers build errors, schedule extremes and random phases
// of small builds with noising and prediction items under random stalls.
// ----------------------------------------------------------------------------
module tb_diffusion_noise_schedule_apply;
    import dnsa_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam longint unsigned ONE_Q32 = 64'd1 << 32;
    localparam longint unsigned COEF_MAX = (64'd1 << 24) - 1;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [15:0]         value;
        logic [STATUS_W-1:0] status;
    } result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [47:0] s_tdata = '0;
    logic [CMD_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    diffusion_noise_schedule_apply u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 aclk = ~aclk;

    // model state
    logic [23:0] keep_coef [0:1023];
    logic [23:0] noise_coef [0:1023];
    longint unsigned sched_product = ONE_Q32;
    bit sched_built = 1'b0;
    int unsigned sched_steps = 0;
    int unsigned reg_beta_start = RST_BETA_START;
    int unsigned reg_beta_end = RST_BETA_END;
    int unsigned reg_num_steps = RST_NUM_STEPS;

    result_t pending_results[$];
    int err_count = 0;
    int unsigned cycle_count = 0;
    bit no_idle = 1'b0;
    int unsigned m_stall = 0;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned sample_mag(logic [15:0] raw, output bit neg);
        neg = raw[15];
        return raw[15] ? (64'd65536 - raw) : raw;
    endfunction

    function automatic logic [15:0] clamp_sample(longint unsigned mag, bit neg);
        if (neg) begin
            if (mag > 32768) mag = 32768;
            return 16'(64'd0 - mag);
        end
        if (mag > 32767) mag = 32767;
        return 16'(mag);
    endfunction

    function automatic logic [STATUS_W-1:0] build_schedule();
        longint unsigned diff, beta, keep, rest, cn;
        if (reg_beta_start == 0 || reg_beta_start > reg_beta_end) begin
            sched_built = 1'b0;
            return STAT_BETA;
        end
        if (reg_num_steps == 0 || reg_num_steps > 1024) begin
            sched_built = 1'b0;
            return STAT_STEP;
        end
        diff = reg_beta_end - reg_beta_start;
        sched_product = ONE_Q32;
        for (int unsigned t = 0; t < reg_num_steps; t++) begin
            beta = reg_beta_start;
            if (reg_num_steps > 1)
                beta += (diff * t + (reg_num_steps - 1) / 2) / (reg_num_steps - 1);
            sched_product = (sched_product * ((64'd1 << 24) - beta) + (64'd1 << 23)) >> 24;
            keep = int_sqrt(sched_product << 16);
            if (keep > COEF_MAX) keep = COEF_MAX;
            rest = ONE_Q32 - sched_product;
            if (rest >= ONE_Q32) begin
                cn = COEF_MAX;
            end else begin
                cn = int_sqrt(rest << 16);
                if (cn > COEF_MAX) cn = COEF_MAX;
            end
            keep_coef[t] = 24'(keep);
            noise_coef[t] = 24'(cn);
        end
        sched_steps = reg_num_steps;
        sched_built = 1'b1;
        return STAT_OK;
    endfunction

    function automatic result_t predict_item(logic [CMD_W-1:0] cmd, logic [9:0] step,
                                             logic [15:0] x, logic [15:0] n);
        result_t r;
        longint unsigned a, b, mx, mn, mag;
        bit nx, nn, neg;
        r = '0;
        if (cmd == CMD_BUILD) begin
            r.status = build_schedule();
        end else if (cmd == CMD_ADD || cmd == CMD_PRED) begin
            if (!sched_built) begin
                r.status = STAT_NOT_BUILT;
            end else if (step >= sched_steps) begin
                r.status = STAT_STEP;
            end else begin
                a = keep_coef[step];
                b = noise_coef[step];
                mx = sample_mag(x, nx);
                mn = sample_mag(n, nn);
                if (cmd == CMD_ADD) begin
                    mx = a * mx;
                    mn = b * mn;
                end else begin
                    mx = mx << 24;
                    mn = b * mn;
                    nn = !nn;
                end
                if (nx == nn) begin
                    neg = nx;
                    mag = mx + mn;
                end else if (mx >= mn) begin
                    neg = nx;
                    mag = mx - mn;
                end else begin
                    neg = nn;
                    mag = mn - mx;
                end
                if (cmd == CMD_ADD) begin
                    mag = (mag + (64'd1 << 23)) >> 24;
                end else if (a == 0) begin
                    if (mag != 0) mag = 32768;
                end else begin
                    mag = (mag + a / 2) / a;
                end
                r.value = clamp_sample(mag, neg);
            end
        end
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned p;
        if (no_idle) return 0;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report(input string what, input int got, input int want);
        err_count++;
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    endtask

    // cycle counter and timeout
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout");
            $display("status: fail");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (m_stall > 0) begin
            m_stall <= m_stall - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            m_stall <= pick_gap();
        end
    end

    // result checker
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report("unexpected item", m_tdata, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata !== want.value) report("value", $signed(m_tdata), $signed(want.value));
                if (m_tuser !== want.status) report("status", m_tuser, want.status);
            end
        end
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [9:0] step,
                             input logic [15:0] x, input logic [15:0] n);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {6'd0, n, x, step};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_item(cmd, step, x, n));
    endtask

    // lower valid and wait for every pending result
    task automatic drain();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
        @(negedge aclk) cfg_we <= 1'b0;
        if (idx == REG_BETA_START) reg_beta_start = val & 24'hFFFFFF;
        else if (idx == REG_BETA_END) reg_beta_end = val & 24'hFFFFFF;
        else if (idx == REG_NUM_STEPS) reg_num_steps = val & 11'h7FF;
    endtask

    task automatic set_schedule(input int unsigned bs, input int unsigned be, input int unsigned ns);
        drain();
        write_reg(REG_BETA_START, bs);
        write_reg(REG_BETA_END, be);
        write_reg(REG_NUM_STEPS, ns);
    endtask

    task automatic test_before_build();
        send_item(CMD_ADD, 10'd0, 16'h1000, 16'h0800);
        send_item(CMD_PRED, 10'd3, 16'h8000, 16'h7FFF);
        send_item(CMD_UNUSED, 10'h3FF, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_build_errors();
        set_schedule(0, 1000, 10);
        send_item(CMD_BUILD, 10'd0, 16'd0, 16'd0);
        set_schedule(5000, 4999, 10);
        send_item(CMD_BUILD, 10'd0, 16'd0, 16'd0);
        send_item(CMD_ADD, 10'd0, 16'h1000, 16'h1000);
        set_schedule(100, 2000, 0);
        send_item(CMD_BUILD, 10'd0, 16'd0, 16'd0);
        set_schedule(100, 2000, 2047);
        send_item(CMD_BUILD, 10'd0, 16'd0, 16'd0);
        set_schedule(100, 2000, 1025);
        send_item(CMD_BUILD, 10'd0, 16'd0, 16'd0);
    endtask

    task automatic test_extremes();
        // single step schedule
        set_schedule(1, 1, 1);
        send_item(CMD_BUILD, 10'd0, 16'd0, 16'd0);
        send_item(CMD_ADD, 10'd0, 16'h7FFF, 16'h7FFF);
        send_item(CMD_PRED, 10'd0, 16'h8000, 16'h8000);
        send_item(CMD_ADD, 10'd1, 16'h1234, 16'h4321);
        // saturating betas drive the keep coefficient to zero
        set_schedule(24'hFFFFFF, 24'hFFFFFF, 3);
        send_item(CMD_BUILD, 10'd0, 16'd0, 16'd0);
        send_item(CMD_PRED, 10'd1, 16'h7FFF, 16'h0000);
        send_item(CMD_PRED, 10'd1, 16'h8000, 16'h0000);
        send_item(CMD_PRED, 10'd2, 16'h0000, 16'h0000);
        send_item(CMD_ADD, 10'd2, 16'h8000, 16'h8000);
        // registers changed after a build leave the table alone
        set_schedule(1, 24'hFFFFFF, 2);
        send_item(CMD_ADD, 10'd2, 16'h0100, 16'hFF00);
        send_item(CMD_BUILD, 10'd0, 16'd0, 16'd0);
        send_item(CMD_PRED, 10'd1, 16'h7FFF, 16'h8000);
        // full length schedules
        set_schedule(RST_BETA_START, RST_BETA_END, RST_NUM_STEPS);
        send_item(CMD_BUILD, 10'd0, 16'd0, 16'd0);
        send_item(CMD_ADD, 10'd999, 16'h7FFF, 16'h8000);
        send_item(CMD_PRED, 10'd999, 16'h0FFF, 16'h1000);
        set_schedule(1678, 335544, 1024);
        send_item(CMD_BUILD, 10'd0, 16'd0, 16'd0);
        send_item(CMD_PRED, 10'h3FF, 16'h8000, 16'h7FFF);
        send_item(CMD_ADD, 10'd0, 16'h0001, 16'hFFFF);
    endtask

    task automatic test_random();
        int unsigned bs, be, ns, p;
        logic [9:0] st;
        logic [CMD_W-1:0] cmd;
        for (int ph = 0; ph < 14; ph++) begin
            no_idle = (ph % 5 == 3);
            ns = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 40);
            p = $urandom_range(0, 9);
            bs = (p < 2) ? $urandom_range(1, 24'hFFFFFF) : $urandom_range(1, 20000);
            be = (p == 0) ? $urandom_range(1, 24'hFFFFFF)
                          : bs + $urandom_range(0, (p < 5) ? 24'hFFFFFF - bs : 400000);
            if (be > 24'hFFFFFF) be = 24'hFFFFFF;
            set_schedule(bs, be, ns);
            send_item(CMD_BUILD, 10'($urandom), 16'($urandom), 16'($urandom));
            for (int k = 0; k < 38; k++) begin
                p = $urandom_range(0, 99);
                cmd = (p < 48) ? CMD_ADD : (p < 95) ? CMD_PRED : (p < 98) ? CMD_UNUSED : CMD_BUILD;
                st = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, ns - 1));
                p = $urandom_range(0, 9);
                send_item(cmd, st,
                          (p == 0) ? 16'h8000 : (p == 1) ? 16'h7FFF : 16'($urandom),
                          (p == 2) ? 16'h8000 : (p == 3) ? 16'h7FFF : 16'($urandom));
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        test_before_build();
        test_build_errors();
        test_extremes();
        test_random();
        drain();
        repeat (50) @(posedge aclk);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
